@@ hdl/qmci_pkg.sv @@
package qmci_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int CODE_W     = 2 * MAX_LEVELS;
    localparam int CB_W       = 2 * (MAX_LEVELS + 1);
    localparam int WORD_W     = 32;
    localparam int OFF_W      = WORD_W + 1;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int FRAC_W     = 16;
    localparam int GRID_W     = PROD_W - FRAC_W;
    localparam int IDX_W      = 17;
    localparam int DEPTH_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CORNERS    = 4;

    localparam logic [WORD_W-1:0]  ORIGIN_RST      = '0;
    localparam logic [WORD_W-1:0]  INV_RST         = 32'd65536;
    localparam logic [DEPTH_W-1:0] TREE_LEVELS_RST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X        = 3'd0,
        REG_ORIGIN_Y        = 3'd1,
        REG_INV_CELL_WIDTH  = 3'd2,
        REG_INV_CELL_HEIGHT = 3'd3,
        REG_TREE_LEVELS     = 3'd4
    } cfg_reg_t;

endpackage

@@ hdl/quadtree_morton_cell_index.sv @@
// Linear quadtree cell index for one bounding box per word.
// Input channel (s_valid/s_ready): box_left, box_top, box_right, box_bottom,
// all 32-bit signed world fixed-point. Output channel (m_valid/m_ready):
// cell_index, cell_depth and index_valid; index and depth read zero when the
// box does not lie inside the grid.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (origin_x,
// origin_y, inv_cell_width, inv_cell_height, tree_levels); other indexes are
// dropped. Write only while no word is in flight.
// Pipeline: four register stages (offset subtract, four parallel 32x32
// multipliers, range check and Morton climb search, index add); m_valid is
// the stage 4 valid. Throughput: one word per cycle while m_ready is high;
// the multiplier stage sets the clock. Each stage advances when its successor
// is empty or advancing, so bubbles fill while the receiver stalls and s_ready
// drops only once all four stages hold words. Nothing is lost or repeated
// under stall.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: origin 0, reciprocals 65536, tree_levels 8.
module quadtree_morton_cell_index (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qmci_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qmci_pkg::WORD_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qmci_pkg::WORD_W-1:0] s_box_left,
    input  logic signed [qmci_pkg::WORD_W-1:0] s_box_top,
    input  logic signed [qmci_pkg::WORD_W-1:0] s_box_right,
    input  logic signed [qmci_pkg::WORD_W-1:0] s_box_bottom,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [qmci_pkg::IDX_W-1:0]        m_cell_index,
    output logic [qmci_pkg::DEPTH_W-1:0]      m_cell_depth,
    output logic                              m_index_valid
);
    import qmci_pkg::*;

    function automatic logic [CODE_W-1:0] interleave(input logic [MAX_LEVELS-1:0] gx,
                                                     input logic [MAX_LEVELS-1:0] gy);
        logic [CODE_W-1:0] code;
        code = '0;
        for (int b = 0; b < MAX_LEVELS; b++) begin
            code[2*b]     = gx[b];
            code[2*b + 1] = gy[b];
        end
        return code;
    endfunction

    // (4^n - 1) / 3 as a sum of powers of four
    function automatic logic [CB_W-1:0] cells_below(input logic [LVL_W:0] n);
        logic [CB_W-1:0] acc;
        acc = '0;
        for (int k = 0; k <= MAX_LEVELS; k++) begin
            if (k < int'(n)) begin
                acc = acc | (CB_W'(1) << (2 * k));
            end
        end
        return acc;
    endfunction

    // configuration registers
    logic [WORD_W-1:0]  origin_x_reg, origin_y_reg;
    logic [WORD_W-1:0]  inv_w_reg, inv_h_reg;
    logic [DEPTH_W-1:0] tree_levels_reg;
    logic [LVL_W-1:0]   levels;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= ORIGIN_RST;
            origin_y_reg    <= ORIGIN_RST;
            inv_w_reg       <= INV_RST;
            inv_h_reg       <= INV_RST;
            tree_levels_reg <= TREE_LEVELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:        origin_x_reg    <= cfg_wdata;
                REG_ORIGIN_Y:        origin_y_reg    <= cfg_wdata;
                REG_INV_CELL_WIDTH:  inv_w_reg       <= cfg_wdata;
                REG_INV_CELL_HEIGHT: inv_h_reg       <= cfg_wdata;
                REG_TREE_LEVELS:     tree_levels_reg <= cfg_wdata[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign levels = (32'(tree_levels_reg) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                         : LVL_W'(tree_levels_reg);

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 1: corner offsets from the origin, exact in 33 bits
    logic [WORD_W-1:0] pos [CORNERS];
    logic [OFF_W-1:0]  off_reg  [CORNERS];
    logic [OFF_W-1:0]  off_next [CORNERS];

    assign pos[0] = s_box_left;
    assign pos[1] = s_box_top;
    assign pos[2] = s_box_right;
    assign pos[3] = s_box_bottom;

    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            if ((i % 2) == 0) begin
                off_next[i] = {pos[i][WORD_W-1], pos[i]}
                            - {origin_x_reg[WORD_W-1], origin_x_reg};
            end else begin
                off_next[i] = {pos[i][WORD_W-1], pos[i]}
                            - {origin_y_reg[WORD_W-1], origin_y_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            off_reg <= off_next;
        end
    end

    // stage 2: scale by the Q16 reciprocal
    logic [GRID_W-1:0] g_reg  [CORNERS];
    logic [GRID_W-1:0] g_next [CORNERS];
    logic [CORNERS-1:0] neg_reg, neg_next;
    logic [PROD_W-1:0] prod [CORNERS];

    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            prod[i] = PROD_W'(off_reg[i][WORD_W-1:0])
                    * PROD_W'(((i % 2) == 0) ? inv_w_reg : inv_h_reg);
            g_next[i]   = prod[i][PROD_W-1:FRAC_W];
            neg_next[i] = off_reg[i][OFF_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            g_reg   <= g_next;
            neg_reg <= neg_next;
        end
    end

    // stage 3: range check, Morton codes and climb height
    logic [CORNERS-1:0] inrange;
    logic               ok3_next, ok3_reg;
    logic [CODE_W-1:0]  lt_code, rb_next, rb_reg, diff;
    logic [LVL_W-1:0]   h_next, h_reg;

    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            inrange[i] = ((g_reg[i] >> levels) == '0) && !neg_reg[i];
        end
        ok3_next = &inrange;
        lt_code  = interleave(g_reg[0][MAX_LEVELS-1:0], g_reg[1][MAX_LEVELS-1:0]);
        rb_next  = interleave(g_reg[2][MAX_LEVELS-1:0], g_reg[3][MAX_LEVELS-1:0]);
        diff     = lt_code ^ rb_next;
        h_next   = '0;
        // highest differing pair wins
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (diff[2*i +: 2] != 2'b00) begin
                h_next = LVL_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            ok3_reg <= ok3_next;
            rb_reg  <= rb_next;
            h_reg   <= h_next;
        end
    end

    // stage 4: climb, add the coarser-level offset, bound check
    logic [CB_W-1:0]    idx_sum;
    logic [LVL_W-1:0]   depth;
    logic               ok4;
    logic [IDX_W-1:0]   idx_next, idx_reg;
    logic [DEPTH_W-1:0] depth_next, depth_reg;
    logic               iv_next, iv_reg;

    always_comb begin
        depth   = levels - h_reg;
        idx_sum = CB_W'(rb_reg >> {h_reg, 1'b0}) + cells_below({1'b0, depth});
        ok4     = ok3_reg && (idx_sum < cells_below({1'b0, levels} + 1'b1));
        if (ok4) begin
            idx_next   = idx_sum[IDX_W-1:0];
            depth_next = DEPTH_W'(depth);
            iv_next    = 1'b1;
        end else begin
            idx_next   = '0;
            depth_next = '0;
            iv_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            idx_reg   <= idx_next;
            depth_reg <= depth_next;
            iv_reg    <= iv_next;
        end
    end

    assign m_valid       = v4_reg;
    assign m_cell_index  = idx_reg;
    assign m_cell_depth  = depth_reg;
    assign m_index_valid = iv_reg;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_stall_holds_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !adv4 |=> v3_reg && $stable(rb_reg) && $stable(h_reg))
        else $error("stage 3 word changed while stalled");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_valid |-> 32'(m_cell_depth) <= 32'(levels))
        else $error("cell depth above effective levels");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_index_valid |-> m_cell_index == '0 && m_cell_depth == '0)
        else $error("invalid result carries nonzero fields");

endmodule
